// ===== rtl/cloud_in_cell_mass_deposit_top_defines.svh =====
// assertion macros for the mass deposit block
`ifndef CLOUD_IN_CELL_MASS_DEPOSIT_TOP_DEFINES_SVH
`define CLOUD_IN_CELL_MASS_DEPOSIT_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define CIC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CIC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CIC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CIC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/cic_pkg.sv =====
`default_nettype none
package cic_pkg;

  localparam int AXIS_CELLS_MAX_DEF = 32;
  localparam int MASS_ACC_BITS_DEF  = 48;

  localparam logic [1:0] MODE_DEPOSIT    = 2'd0;
  localparam logic [1:0] MODE_READ       = 2'd1;
  localparam logic [1:0] MODE_READ_CLEAR = 2'd2;

  localparam logic [2:0] REG_GRID_NX  = 3'd0;
  localparam logic [2:0] REG_GRID_NY  = 3'd1;
  localparam logic [2:0] REG_GRID_NZ  = 3'd2;
  localparam logic [2:0] REG_INV_X    = 3'd3;
  localparam logic [2:0] REG_INV_Y    = 3'd4;
  localparam logic [2:0] REG_INV_Z    = 3'd5;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [16:0] HALF_Q16 = 17'h08000;
  localparam logic [16:0] W_TOP    = 17'h18000;

  // corner select, bit 2 picks x neighbour, bit 1 y, bit 0 z
  localparam logic [2:0] CORNER_SEL [8] = '{
    3'b000, 3'b100, 3'b010, 3'b001, 3'b110, 3'b011, 3'b101, 3'b111
  };

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] particle_mass;
    logic [14:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [47:0] cell_mass;
    logic        index_out_of_range;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/cloud_in_cell_mass_deposit_top.sv =====
// cloud-in-cell mass deposit onto a periodic 3-D grid held in one memory
// in_* channel: one beat carries a deposit (mode 0), a read (mode 1) or a
// read-and-clear (mode 2); mode 3 beats are taken and dropped
// out_* channel: one beat for every read, carrying the cell sum and a flag
// for an index beyond nx*ny*nz; deposits give no beat
// cfg_*: register bank, six registers at byte addresses 0..20, pready high
// one item is worked at a time; in_stall is high while an item is in work
// deposit: worked through the 32-step bit-serial modulo of the scaled
// positions and eight read-modify-write passes, states C0 to C6, through
// the single-port grid memory and the shared 32x32 multiplier
// read: states R0 to R3, the result registered on leaving R3
// after reset the grid is swept to zero, one cell a cycle, over all
// AXIS_CELLS_MAX**3 cells (32768 by default) with in_stall high;
// register writes are taken during the sweep
// a stalled result holds in the output register and the block waits
module cloud_in_cell_mass_deposit_top #(
  parameter int AXIS_CELLS_MAX = cic_pkg::AXIS_CELLS_MAX_DEF,
  parameter int MASS_ACC_BITS  = cic_pkg::MASS_ACC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire cic_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output cic_pkg::out_t     out_data,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import cic_pkg::*;

  `include "cloud_in_cell_mass_deposit_top_defines.svh"

  localparam int DEPTH = AXIS_CELLS_MAX * AXIS_CELLS_MAX * AXIS_CELLS_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(AXIS_CELLS_MAX + 1);
  localparam int RW    = NW + 1;
  localparam int CW    = $clog2(AXIS_CELLS_MAX);
  localparam int SUM_W = ((MASS_ACC_BITS > 34) ? MASS_ACC_BITS : 34) + 1;
  localparam logic [MASS_ACC_BITS-1:0] ACC_MAX = {MASS_ACC_BITS{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE, ST_MX, ST_MY, ST_MZ, ST_LD, ST_MOD, ST_NB,
    ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6,
    ST_R0, ST_R1, ST_R2, ST_R3
  } state_t;

  // configuration registers
  logic [5:0]  grid_nx_r, grid_ny_r, grid_nz_r;
  logic [31:0] inv_x_r, inv_y_r, inv_z_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_nx_r <= 6'd32;
      grid_ny_r <= 6'd32;
      grid_nz_r <= 6'd32;
      inv_x_r   <= 32'd65536;
      inv_y_r   <= 32'd65536;
      inv_z_r   <= 32'd65536;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_GRID_NX: grid_nx_r <= cfg_pwdata[5:0];
        REG_GRID_NY: grid_ny_r <= cfg_pwdata[5:0];
        REG_GRID_NZ: grid_nz_r <= cfg_pwdata[5:0];
        REG_INV_X:   inv_x_r   <= cfg_pwdata;
        REG_INV_Y:   inv_y_r   <= cfg_pwdata;
        REG_INV_Z:   inv_z_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_GRID_NX: cfg_prdata = {26'd0, grid_nx_r};
      REG_GRID_NY: cfg_prdata = {26'd0, grid_ny_r};
      REG_GRID_NZ: cfg_prdata = {26'd0, grid_nz_r};
      REG_INV_X:   cfg_prdata = inv_x_r;
      REG_INV_Y:   cfg_prdata = inv_y_r;
      REG_INV_Z:   cfg_prdata = inv_z_r;
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // clamped axis sizes
  logic [NW-1:0] n_ax [3];
  logic [5:0]    greg [3];

  assign greg[0] = grid_nx_r;
  assign greg[1] = grid_ny_r;
  assign greg[2] = grid_nz_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (greg[a] == 6'd0) n_ax[a] = NW'(1);
      else if ({1'b0, greg[a]} > 7'(AXIS_CELLS_MAX)) n_ax[a] = NW'(AXIS_CELLS_MAX);
      else n_ax[a] = NW'(greg[a]);
    end
  end

  // working registers
  state_t                    state_r;
  in_t                       item_r;
  logic [63:0]               prod_r;
  logic [31:0]               mul_a, mul_b;
  logic [31:0]               q_r   [3];
  logic [15:0]               f_r   [3];
  logic [RW-1:0]             rem_r [3];
  logic [4:0]                bit_cnt_r;
  logic [CW-1:0]             coord_r [3][2];
  logic [16:0]               wt_r    [3][2];
  logic [2:0]                corner_r;
  logic [AW-1:0]             idx_r;
  logic [33:0]               add_r;
  logic                      oor_r;
  logic                      clearing_r;
  logic [AW-1:0]             clr_cnt_r;
  logic                      out_valid_r;
  out_t                      out_data_r;
  logic [MASS_ACC_BITS-1:0]  rd_data_r;

  // memory port controls
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_addr;
  logic [MASS_ACC_BITS-1:0]  mem_wdata;
  logic [SUM_W-1:0]          sum;
  logic [63:0]               rd_wide;
  logic [2:0]                sel;
  logic                      out_free;

  assign in_stall  = clearing_r | (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign sel       = CORNER_SEL[corner_r];
  assign out_free  = ~out_valid_r | ~out_stall;
  assign sum       = SUM_W'(rd_data_r) + SUM_W'(add_r);
  assign rd_wide   = 64'(rd_data_r);

  // shared multiplier operand selection
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      ST_MX: begin mul_a = item_r.pos_x; mul_b = inv_x_r; end
      ST_MY: begin mul_a = item_r.pos_y; mul_b = inv_y_r; end
      ST_MZ: begin mul_a = item_r.pos_z; mul_b = inv_z_r; end
      ST_C0: begin
        mul_a = 32'(coord_r[0][sel[2]]);
        mul_b = 32'(n_ax[1]);
      end
      ST_C1: begin
        mul_a = prod_r[31:0] + 32'(coord_r[1][sel[1]]);
        mul_b = 32'(n_ax[2]);
      end
      ST_C2: begin
        mul_a = 32'(wt_r[0][sel[2]]);
        mul_b = 32'(wt_r[1][sel[1]]);
      end
      ST_C3: begin
        mul_a = 32'((prod_r + 64'(HALF_Q16)) >> 16);
        mul_b = 32'(wt_r[2][sel[0]]);
      end
      ST_C4: begin
        mul_a = 32'((prod_r + 64'(HALF_Q16)) >> 16);
        mul_b = item_r.particle_mass;
      end
      ST_R0: begin mul_a = 32'(n_ax[0]); mul_b = 32'(n_ax[1]); end
      ST_R1: begin mul_a = prod_r[31:0]; mul_b = 32'(n_ax[2]); end
      default: ;
    endcase
  end

  // memory port use
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = idx_r;
    mem_wdata = '0;
    if (clearing_r) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt_r;
    end else begin
      unique case (state_r)
        ST_C5: mem_re = 1'b1;
        ST_C6: begin
          mem_we    = 1'b1;
          mem_wdata = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : sum[MASS_ACC_BITS-1:0];
        end
        ST_R2: begin
          mem_addr = AW'(item_r.cell_index);
          mem_re   = ~((32'(item_r.cell_index) >= prod_r[31:0]) ||
                       (32'(item_r.cell_index) >= 32'(DEPTH)));
        end
        ST_R3: begin
          mem_addr = AW'(item_r.cell_index);
          mem_we   = out_free & ~oor_r & (item_r.mode == MODE_READ_CLEAR);
        end
        default: ;
      endcase
    end
  end

  // grid memory, one port, registered read
  logic [MASS_ACC_BITS-1:0] grid_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_r <= grid_mem[mem_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) clearing_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            item_r <= in_data;
            priority if (in_data.mode == MODE_DEPOSIT) state_r <= ST_MX;
            else if (in_data.mode == MODE_READ || in_data.mode == MODE_READ_CLEAR)
              state_r <= ST_R0;
            else state_r <= ST_IDLE;
          end
        end
        ST_MX: state_r <= ST_MY;
        ST_MY: begin
          q_r[0]  <= prod_r[63:32];
          f_r[0]  <= prod_r[31:16];
          state_r <= ST_MZ;
        end
        ST_MZ: begin
          q_r[1]  <= prod_r[63:32];
          f_r[1]  <= prod_r[31:16];
          state_r <= ST_LD;
        end
        ST_LD: begin
          q_r[2]    <= prod_r[63:32];
          f_r[2]    <= prod_r[31:16];
          bit_cnt_r <= 5'd0;
          for (int a = 0; a < 3; a++) rem_r[a] <= '0;
          state_r   <= ST_MOD;
        end
        // restoring modulo, one quotient bit per cycle on all three axes
        ST_MOD: begin
          for (int a = 0; a < 3; a++) begin
            logic [RW-1:0] t;
            t = {rem_r[a][RW-2:0], q_r[a][31]};
            rem_r[a] <= (t >= RW'(n_ax[a])) ? t - RW'(n_ax[a]) : t;
            q_r[a]   <= {q_r[a][30:0], 1'b0};
          end
          bit_cnt_r <= bit_cnt_r + 5'd1;
          if (bit_cnt_r == 5'd31) state_r <= ST_NB;
        end
        // home and neighbour cells, weights
        ST_NB: begin
          for (int a = 0; a < 3; a++) begin
            logic [NW-1:0] c;
            logic [16:0]   w;
            c = NW'(rem_r[a]);
            coord_r[a][0] <= CW'(c);
            if ({1'b0, f_r[a]} > HALF_Q16) begin
              w = W_TOP - {1'b0, f_r[a]};
              coord_r[a][1] <= (c + NW'(1) == n_ax[a]) ? '0 : CW'(c + NW'(1));
            end else begin
              w = {1'b0, f_r[a]} + HALF_Q16;
              coord_r[a][1] <= (c == '0) ? CW'(n_ax[a] - NW'(1)) : CW'(c - NW'(1));
            end
            wt_r[a][0] <= w;
            wt_r[a][1] <= ONE_Q16 - w;
          end
          corner_r <= 3'd0;
          state_r  <= ST_C0;
        end
        ST_C0: state_r <= ST_C1;
        ST_C1: state_r <= ST_C2;
        ST_C2: begin
          idx_r   <= AW'(prod_r[31:0] + 32'(coord_r[2][sel[0]]));
          state_r <= ST_C3;
        end
        ST_C3: state_r <= ST_C4;
        ST_C4: state_r <= ST_C5;
        ST_C5: begin
          add_r   <= 34'((prod_r + 64'(HALF_Q16)) >> 16);
          state_r <= ST_C6;
        end
        ST_C6: begin
          corner_r <= corner_r + 3'd1;
          state_r  <= (corner_r == 3'd7) ? ST_IDLE : ST_C0;
        end
        ST_R0: state_r <= ST_R1;
        ST_R1: state_r <= ST_R2;
        ST_R2: begin
          oor_r   <= ~mem_re;
          state_r <= ST_R3;
        end
        ST_R3: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r.index_out_of_range <= oor_r;
            if (oor_r) out_data_r.cell_mass <= 48'd0;
            else if (|rd_wide[63:48]) out_data_r.cell_mass <= {48{1'b1}};
            else out_data_r.cell_mass <= rd_wide[47:0];
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // checks
  `CIC_ASSERT_IMP(a_clear_stalls, clk, rst_n, clearing_r, in_stall)
  `CIC_ASSERT_IMP(a_take_idle, clk, rst_n, in_valid && !in_stall, state_r == ST_IDLE)
  `CIC_ASSERT_NXT(a_rd_hold, clk, rst_n, state_r == ST_R3 && out_valid_r && out_stall,
                  state_r == ST_R3)
  `CIC_ASSERT_IMP(a_one_port, clk, rst_n, state_r == ST_C6, !mem_re && !clearing_r)

endmodule
`default_nettype wire

// ===== tb/cloud_in_cell_mass_deposit_top_tb.sv =====
`timescale 1ns / 1ps
module cloud_in_cell_mass_deposit_top_tb;
  import cic_pkg::*;

  localparam int GRID_CELLS = 32768;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [47:0] ACC_MAX = 48'hFFFF_FFFF_FFFF;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  cloud_in_cell_mass_deposit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // shadow grid and shadow registers
  logic [47:0] cell_shadow [GRID_CELLS];
  logic [5:0] sh_nx, sh_ny, sh_nz;
  logic [31:0] sh_inv_x, sh_inv_y, sh_inv_z;

  in_t item_q[$];
  out_t read_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  longint cycles = 0;

  function automatic int clamp_axis(logic [5:0] r);
    if (r < 1) return 1;
    if (r > 32) return 32;
    return int'(r);
  endfunction

  // home cell, neighbor cell and home weight for one axis
  task automatic split_axis(input logic [31:0] pos, input logic [31:0] inv,
                            input int n, output int home, output int nbr,
                            output logic [16:0] w);
    logic [63:0] s;
    logic [15:0] f;
    s = 64'(pos) * 64'(inv);
    home = int'((s >> 32) % n);
    f = s[31:16];
    if (17'(f) > HALF_Q16) begin
      w = W_TOP - 17'(f);
      nbr = (home + 1) % n;
    end else begin
      w = 17'(f) + HALF_Q16;
      nbr = (home + n - 1) % n;
    end
  endtask

  // apply one beat to the shadow grid, queue a read result when one is due
  task automatic deposit_or_read(input in_t it);
    int nx, ny, nz, idx, a, b, d;
    int xs[2], ys[2], zs[2];
    logic [16:0] wx[2], wy[2], wz[2];
    logic [63:0] ab, abc, add;
    out_t r;
    nx = clamp_axis(sh_nx);
    ny = clamp_axis(sh_ny);
    nz = clamp_axis(sh_nz);
    if (it.mode == MODE_DEPOSIT) begin
      split_axis(it.pos_x, sh_inv_x, nx, xs[0], xs[1], wx[0]);
      split_axis(it.pos_y, sh_inv_y, ny, ys[0], ys[1], wy[0]);
      split_axis(it.pos_z, sh_inv_z, nz, zs[0], zs[1], wz[0]);
      wx[1] = ONE_Q16 - wx[0];
      wy[1] = ONE_Q16 - wy[0];
      wz[1] = ONE_Q16 - wz[0];
      for (int c = 0; c < 8; c++) begin
        a = CORNER_SEL[c][2];
        b = CORNER_SEL[c][1];
        d = CORNER_SEL[c][0];
        idx = (xs[a] * ny + ys[b]) * nz + zs[d];
        ab = (64'(wx[a]) * 64'(wy[b]) + 64'(HALF_Q16)) >> 16;
        abc = (ab * 64'(wz[d]) + 64'(HALF_Q16)) >> 16;
        add = (64'(it.particle_mass) * abc + 64'(HALF_Q16)) >> 16;
        if (add > 64'(ACC_MAX - cell_shadow[idx])) cell_shadow[idx] = ACC_MAX;
        else cell_shadow[idx] = cell_shadow[idx] + add[47:0];
      end
    end else if (it.mode == MODE_READ || it.mode == MODE_READ_CLEAR) begin
      idx = int'(it.cell_index);
      if (idx >= nx * ny * nz) begin
        r.cell_mass = '0;
        r.index_out_of_range = 1'b1;
      end else begin
        r.cell_mass = cell_shadow[idx];
        r.index_out_of_range = 1'b0;
        if (it.mode == MODE_READ_CLEAR) cell_shadow[idx] = '0;
      end
      read_q.push_back(r);
    end
  endtask

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      deposit_or_read(in_data);
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // hold the stalled beat
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      in_valid <= 1'b0;
    end else if (item_q.size() > 0) begin
      in_data <= item_q.pop_front();
      in_valid <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 17);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // monitor and receiver stalls
  int sink_gap = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (read_q.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, out_data);
        errors++;
      end else begin
        out_t e;
        e = read_q.pop_front();
        if (e.cell_mass !== out_data.cell_mass) begin
          $display("%0t cell_mass: expected %h actual %h", $time, e.cell_mass,
                   out_data.cell_mass);
          errors++;
        end
        if (e.index_out_of_range !== out_data.index_out_of_range) begin
          $display("%0t index_out_of_range: expected %b actual %b", $time,
                   e.index_out_of_range, out_data.index_out_of_range);
          errors++;
        end
      end
    end
    if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      sink_gap <= $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_GRID_NX: sh_nx = val[5:0];
      REG_GRID_NY: sh_ny = val[5:0];
      REG_GRID_NZ: sh_nz = val[5:0];
      REG_INV_X: sh_inv_x = val;
      REG_INV_Y: sh_inv_y = val;
      REG_INV_Z: sh_inv_z = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [5:0] nx, input logic [5:0] ny, input logic [5:0] nz,
                          input logic [31:0] ix, input logic [31:0] iy, input logic [31:0] iz);
    reg_write(REG_GRID_NX, 32'(nx));
    reg_write(REG_GRID_NY, 32'(ny));
    reg_write(REG_GRID_NZ, 32'(nz));
    reg_write(REG_INV_X, ix);
    reg_write(REG_INV_Y, iy);
    reg_write(REG_INV_Z, iz);
  endtask

  // wait, sampling on the falling edge, until every beat is taken and answered
  // and the block is idle again
  task automatic drain();
    @(negedge clk);
    while (item_q.size() > 0 || in_valid || in_stall || read_q.size() > 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_t mk(input logic [1:0] m, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z,
                             input logic [31:0] ms, input logic [14:0] ci);
    in_t it;
    it.mode = m; it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.particle_mass = ms; it.cell_index = ci;
    return it;
  endfunction

  function automatic logic [31:0] rnd_pos(input int n, input logic [31:0] inv);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      default: begin
        if (inv == 32'h0001_0000) return $urandom_range(0, n * 65536 - 1);
        return $urandom;
      end
    endcase
  endfunction

  // random phase: deposits with reads of random in-range and random cells, and unused-mode beats
  task automatic random_phase(input int count);
    int nx, ny, nz, tot;
    logic [31:0] ms;
    nx = clamp_axis(sh_nx);
    ny = clamp_axis(sh_ny);
    nz = clamp_axis(sh_nz);
    tot = nx * ny * nz;
    for (int i = 0; i < count; i++) begin
      int k;
      k = $urandom_range(0, 19);
      ms = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
      if (k < 10)
        item_q.push_back(mk(MODE_DEPOSIT, rnd_pos(nx, sh_inv_x), rnd_pos(ny, sh_inv_y),
                            rnd_pos(nz, sh_inv_z), ms, 15'($urandom)));
      else if (k < 18)
        item_q.push_back(mk(k[0] ? MODE_READ : MODE_READ_CLEAR, $urandom, $urandom,
                            $urandom, $urandom,
                            (k < 16) ? 15'($urandom_range(0, tot - 1)) : 15'($urandom)));
      else
        item_q.push_back(mk(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom,
                            15'($urandom)));
    end
  endtask

  initial begin
    for (int i = 0; i < GRID_CELLS; i++) cell_shadow[i] = '0;
    sh_nx = 6'd32; sh_ny = 6'd32; sh_nz = 6'd32;
    sh_inv_x = 32'h0001_0000; sh_inv_y = 32'h0001_0000; sh_inv_z = 32'h0001_0000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default grid, extremes of every field
    item_q.push_back(mk(MODE_DEPOSIT, 32'h0000_8000, 32'h0001_8001, 32'h0000_0000,
                        32'h0001_0000, '0));
    item_q.push_back(mk(MODE_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 15'h7FFF));
    item_q.push_back(mk(MODE_READ, '0, '0, '0, '0, 15'd0));
    item_q.push_back(mk(MODE_READ, '0, '0, '0, '0, 15'd1024 + 15'd32));
    item_q.push_back(mk(MODE_READ_CLEAR, '0, '0, '0, '0, 15'd0));
    item_q.push_back(mk(MODE_READ, '0, '0, '0, '0, 15'd0));
    item_q.push_back(mk(MODE_UNUSED, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF, 15'd0));
    item_q.push_back(mk(MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 15'h7FFF));
    // deposit full mass into one cell six times, then read and clear it
    for (int i = 0; i < 6; i++)
      item_q.push_back(mk(MODE_DEPOSIT, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                          32'hFFFF_FFFF, '0));
    item_q.push_back(mk(MODE_READ_CLEAR, '0, '0, '0, '0, 15'd0));
    drain();

    // single-cell axes, zero and oversize size clamps, zero inverse size, read out of range
    set_grid(6'd0, 6'd1, 6'd63, 32'd0, 32'hFFFF_FFFF, 32'd1);
    item_q.push_back(mk(MODE_DEPOSIT, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF,
                        32'h0003_0000, '0));
    item_q.push_back(mk(MODE_READ, '0, '0, '0, '0, 15'd0));
    item_q.push_back(mk(MODE_READ, '0, '0, '0, '0, 15'd31));
    item_q.push_back(mk(MODE_READ_CLEAR, '0, '0, '0, '0, 15'd32));
    item_q.push_back(mk(MODE_READ, '0, '0, '0, '0, 15'h7FFF));
    random_phase(40);
    drain();

    // random phases over several grid settings
    set_grid(6'd4, 6'd3, 6'd2, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000);
    random_phase(120);
    drain();
    set_grid(6'd32, 6'd32, 6'd32, $urandom, $urandom, $urandom);
    random_phase(120);
    drain();
    set_grid(6'd1, 6'd2, 6'd1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    random_phase(100);
    drain();
    // last part without idling
    quiet = 1'b1;
    set_grid(6'($urandom_range(1, 8)), 6'($urandom_range(1, 8)), 6'($urandom_range(1, 8)),
             32'h0001_0000, $urandom, 32'h0001_0000);
    random_phase(120);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== cloud_in_cell_mass_deposit_top.f =====
+incdir+rtl
rtl/cic_pkg.sv
rtl/cloud_in_cell_mass_deposit_top.sv
tb/cloud_in_cell_mass_deposit_top_tb.sv
